/* rtl/core/fcdc_pkg.sv */
// ----------------------------------------------------------------------------
// fcdc_pkg: shared types and constants of the fan curve duty controller
// Request payloads, result codes, register indexes and the curve bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fcdc_pkg;

	localparam logic [6:0] FULL_DUTY = 7'd100;

	localparam logic [2:0] REASON_INTERP   = 3'd0;
	localparam logic [2:0] REASON_BELOW    = 3'd1;
	localparam logic [2:0] REASON_ABOVE    = 3'd2;
	localparam logic [2:0] REASON_NO_TEMP  = 3'd3;
	localparam logic [2:0] REASON_SILENCE  = 3'd4;

	localparam logic [2:0] REG_POINT_COUNT   = 3'd0;
	localparam logic [2:0] REG_POINT_TEMPS   = 3'd1;
	localparam logic [2:0] REG_POINT_DUTIES  = 3'd2;
	localparam logic [2:0] REG_SKIP_MASK0    = 3'd3;
	localparam logic [2:0] REG_SKIP_MASK1    = 3'd4;
	localparam logic [2:0] REG_SILENCE_LIMIT = 3'd5;
	localparam logic [2:0] REG_PROFILE_EN    = 3'd6;

	localparam logic [15:0] SILENCE_RESET = 16'd60;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic       func;
		logic       slot;
		logic [5:0] channel;
		logic [7:0] temp_value;
		logic       parse_ok;
		logic       last_in_report;
		logic       sensor_unreliable;
	} item_t;

	typedef struct packed {
		logic [6:0] duty_percent;
		logic [2:0] duty_reason;
	} result_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [63:0] value;
	} cfg_req_t;

	// fixed = result already decided by the front; otherwise evaluate the curve at temp
	typedef struct packed {
		logic       fixed;
		result_t    res;
		logic [7:0] temp;
	} entry_t;

	typedef struct packed {
		logic [3:0]      point_count;
		logic [7:0][7:0] temps;
		logic [7:0][7:0] duties;
	} curve_t;

	function automatic logic [6:0] sat_duty(input logic [7:0] d);
		sat_duty = (d > 8'(FULL_DUTY)) ? FULL_DUTY : d[6:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/fcdc_stream_if.sv */
// ----------------------------------------------------------------------------
// fcdc_stream_if: valid/ready channel
// Carries one request of payload type T per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcdc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/fan_curve_duty_controller.sv */
// ----------------------------------------------------------------------------
// fan_curve_duty_controller: piecewise linear fan curve with silence watchdog
// Temperature reports in, fan duty results out, seven configuration registers.
// ----------------------------------------------------------------------------
// Ticks and readings are taken one per cycle while the two-entry job queue
// has room. A result decided by the front (silence timeout, no temperature,
// unreliable sensors) is queued, then registered in the back before it is offered.
// A curve lookup is run by the back sequencer: it compares one point per cycle
// (the walk stops at the first point above the temperature, or after the
// last of point_count points, capped at MAX_POINTS and at eight), then for an
// interpolated duty a multiply step, a bit-serial divide of 17 quotient bits
// and a finish step. Below the first point or above the last the result skips
// these steps. The back starts its next job only once its result has moved
// to the output register, which holds it until taken while the front keeps
// filling the queue. The configuration port is always ready.
`default_nettype none

module fan_curve_duty_controller #(
	parameter int NUM_SLOTS    = 2,
	parameter int MAX_POINTS   = 8,
	parameter int NUM_CHANNELS = 64,
	parameter int TEMP_BITS    = 8
) (
	input wire            clk,
	input wire            arst_n,
	fcdc_stream_if.sink   reading,
	fcdc_stream_if.source result,
	fcdc_stream_if.sink   cfg
);

	logic              item_fire;
	logic              cfg_fire;
	logic              push;
	fcdc_pkg::entry_t  push_entry;
	fcdc_pkg::curve_t  curve;
	logic              q_full;
	logic              q_valid;
	fcdc_pkg::entry_t  q_entry;
	logic              q_pop;
	logic              out_valid;
	fcdc_pkg::result_t out_data;

	assign reading.ready = !q_full;
	assign cfg.ready     = 1'b1;
	assign item_fire     = reading.valid && !q_full;
	assign cfg_fire      = cfg.valid;
	assign result.valid  = out_valid;
	assign result.data   = out_data;

	fcdc_front #(
		.NUM_SLOTS    (NUM_SLOTS),
		.NUM_CHANNELS (NUM_CHANNELS),
		.TEMP_BITS    (TEMP_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (item_fire),
		.item      (reading.data),
		.cfg_fire  (cfg_fire),
		.cfg_req   (cfg.data),
		.push      (push),
		.entry     (push_entry),
		.curve     (curve)
	);

	fcdc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry),
		.pop        (q_pop)
	);

	fcdc_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.curve     (curve),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (result.ready)
	);

endmodule

`default_nettype wire

/* rtl/core/fcdc_front.sv */
// ----------------------------------------------------------------------------
// fcdc_front: register file, report tracking and watchdog
// Accepts readings and ticks, updates state and queues one job per result.
// ----------------------------------------------------------------------------
`default_nettype none

module fcdc_front #(
	parameter int NUM_SLOTS    = 2,
	parameter int NUM_CHANNELS = 64,
	parameter int TEMP_BITS    = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_fire,
	input  wire fcdc_pkg::item_t    item,
	input  wire                     cfg_fire,
	input  wire fcdc_pkg::cfg_req_t cfg_req,
	output logic                    push,
	output fcdc_pkg::entry_t        entry,
	output fcdc_pkg::curve_t        curve
);

	localparam int         TOP_INT  = (TEMP_BITS >= 8) ? 255 : (1 << TEMP_BITS) - 1;
	localparam logic [7:0] TEMP_TOP = 8'(TOP_INT);

	logic [3:0]  point_count_q;
	logic [63:0] point_temps_q;
	logic [63:0] point_duties_q;
	logic [63:0] mask0_q;
	logic [63:0] mask1_q;
	logic [15:0] limit_q;
	logic        enable_q;
	logic [7:0]  report_max_q;
	logic        report_good_q;
	logic [7:0]  slot_max_q [NUM_SLOTS];
	logic        have_q;
	logic [15:0] sec_q;
	logic        armed_q;

	logic [7:0]  temp_sat;
	logic        slot_ok;
	logic        chan_ok;
	logic        skip;
	logic        counted;
	logic [7:0]  rmax_new;
	logic        good_new;
	logic        store;
	logic [7:0]  slot_new [NUM_SLOTS];
	logic [7:0]  hot;
	logic        have_new;
	logic [15:0] sec_inc;
	logic        timeout;
	logic        arm_write;
	logic        enable_new;

	always_comb begin
		temp_sat = (item.temp_value > TEMP_TOP) ? TEMP_TOP : item.temp_value;
		slot_ok  = int'(item.slot) < NUM_SLOTS;
		chan_ok  = int'(item.channel) < NUM_CHANNELS;
		skip     = item.slot ? mask1_q[item.channel] : mask0_q[item.channel];
		counted  = item.parse_ok && slot_ok && chan_ok && !skip;
		rmax_new = (counted && temp_sat > report_max_q) ? temp_sat : report_max_q;
		good_new = report_good_q || counted;
		store    = !item.func && item.last_in_report && good_new && slot_ok;
		hot      = 8'd0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_new[s] = (store && int'(item.slot) == s) ? rmax_new : slot_max_q[s];
			if (slot_new[s] > hot) begin
				hot = slot_new[s];
			end
		end
		have_new = have_q || store;
		sec_inc  = (sec_q == 16'hFFFF) ? sec_q : sec_q + 16'd1;
		timeout  = armed_q && (sec_inc > limit_q);

		push = item_fire && (item.func ? timeout : (item.last_in_report && armed_q));

		entry.temp = hot;
		if (item.func) begin
			entry.fixed            = 1'b1;
			entry.res.duty_percent = fcdc_pkg::FULL_DUTY;
			entry.res.duty_reason  = fcdc_pkg::REASON_SILENCE;
		end else if (!have_new || item.sensor_unreliable) begin
			entry.fixed            = 1'b1;
			entry.res.duty_percent = fcdc_pkg::FULL_DUTY;
			entry.res.duty_reason  = fcdc_pkg::REASON_NO_TEMP;
		end else begin
			entry.fixed            = 1'b0;
			entry.res.duty_percent = fcdc_pkg::FULL_DUTY;
			entry.res.duty_reason  = fcdc_pkg::REASON_INTERP;
		end

		arm_write  = (cfg_req.index == fcdc_pkg::REG_POINT_COUNT) ||
		             (cfg_req.index == fcdc_pkg::REG_POINT_TEMPS) ||
		             (cfg_req.index == fcdc_pkg::REG_POINT_DUTIES) ||
		             (cfg_req.index == fcdc_pkg::REG_PROFILE_EN);
		enable_new = (cfg_req.index == fcdc_pkg::REG_PROFILE_EN) ? cfg_req.value[0] : enable_q;

		curve.point_count = point_count_q;
		curve.temps       = point_temps_q;
		curve.duties      = point_duties_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q  <= '0;
			point_temps_q  <= '0;
			point_duties_q <= '0;
			mask0_q        <= '0;
			mask1_q        <= '0;
			limit_q        <= fcdc_pkg::SILENCE_RESET;
			enable_q       <= 1'b0;
			report_max_q   <= '0;
			report_good_q  <= 1'b0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_max_q[s] <= '0;
			end
			have_q  <= 1'b0;
			sec_q   <= '0;
			armed_q <= 1'b0;
		end else begin
			if (item_fire) begin
				if (item.func) begin
					if (armed_q) begin
						sec_q <= sec_inc;
						if (timeout) begin
							armed_q <= 1'b0;
						end
					end
				end else if (item.last_in_report) begin
					report_max_q  <= '0;
					report_good_q <= 1'b0;
					if (store) begin
						have_q <= 1'b1;
						sec_q  <= '0;
						for (int s = 0; s < NUM_SLOTS; s++) begin
							slot_max_q[s] <= slot_new[s];
						end
					end
				end else begin
					report_max_q  <= rmax_new;
					report_good_q <= good_new;
				end
			end
			if (cfg_fire) begin
				case (cfg_req.index)
					fcdc_pkg::REG_POINT_COUNT:   point_count_q  <= cfg_req.value[3:0];
					fcdc_pkg::REG_POINT_TEMPS:   point_temps_q  <= cfg_req.value;
					fcdc_pkg::REG_POINT_DUTIES:  point_duties_q <= cfg_req.value;
					fcdc_pkg::REG_SKIP_MASK0:    mask0_q        <= cfg_req.value;
					fcdc_pkg::REG_SKIP_MASK1:    mask1_q        <= cfg_req.value;
					fcdc_pkg::REG_SILENCE_LIMIT: limit_q        <= cfg_req.value[15:0];
					fcdc_pkg::REG_PROFILE_EN:    enable_q       <= cfg_req.value[0];
					default: ;
				endcase
				if (arm_write) begin
					if (enable_new) begin
						if (!armed_q) begin
							sec_q <= '0;
						end
						armed_q <= 1'b1;
					end else begin
						armed_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/fcdc_queue.sv */
// ----------------------------------------------------------------------------
// fcdc_queue: short job queue between front and back
// Small FIFO; lets the front keep accepting while the back evaluates.
// ----------------------------------------------------------------------------
`default_nettype none

module fcdc_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire fcdc_pkg::entry_t push_entry,
	output logic                  full,
	output logic                  pop_valid,
	output fcdc_pkg::entry_t      pop_entry,
	input  wire                   pop
);

	localparam int DEPTH = fcdc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fcdc_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		full      = count_q == (PTR_W + 1)'(DEPTH);
		pop_valid = count_q != '0;
		pop_entry = mem_q[rd_q];
		do_push   = push && !full;
		do_pop    = pop && pop_valid;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/fcdc_back.sv */
// ----------------------------------------------------------------------------
// fcdc_back: curve walk, interpolation and result register
// Walks points one per cycle, multiplies once, divides one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcdc_back #(
	parameter int MAX_POINTS = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   q_valid,
	input  wire fcdc_pkg::entry_t q_entry,
	output logic                  q_pop,
	input  wire fcdc_pkg::curve_t curve,
	output logic                  out_valid,
	output fcdc_pkg::result_t     out_data,
	input  wire                   out_ready
);

	localparam logic [3:0] NP    = 4'((MAX_POINTS < 8) ? MAX_POINTS : 8);
	localparam int         DVD_W = 17;

	typedef enum logic [2:0] {S_IDLE, S_WALK, S_MUL, S_DIV, S_FIN, S_DONE} state_t;

	state_t            state_q;
	logic              out_valid_q;
	fcdc_pkg::result_t out_data_q;
	fcdc_pkg::result_t res_q;
	logic [7:0]        temp_q;
	logic [3:0]        idx_q;
	logic signed [8:0] dd_q;
	logic [7:0]        dt_q;
	logic [7:0]        den_q;
	logic [7:0]        d0_q;
	logic              neg_q;
	logic [9:0]        rem_q;
	logic [DVD_W-1:0]  qd_q;
	logic [4:0]        cnt_q;

	logic [3:0]         n_lim;
	logic [7:0]         t_cur;
	logic [7:0]         t_prev;
	logic [7:0]         d_cur;
	logic [7:0]         d_prev;
	logic signed [17:0] prod;
	logic signed [18:0] v;
	logic [18:0]        dvd;
	logic [8:0]         dsor;
	logic [9:0]         rsh;
	logic               ge;
	logic [18:0]        sq;
	logic [18:0]        sum;
	logic [6:0]         duty_fin;

	always_comb begin
		n_lim  = (curve.point_count > NP) ? NP : curve.point_count;
		t_cur  = curve.temps[idx_q[2:0]];
		t_prev = curve.temps[idx_q[2:0] - 3'd1];
		d_cur  = curve.duties[idx_q[2:0]];
		d_prev = curve.duties[idx_q[2:0] - 3'd1];
		dsor   = {den_q, 1'b0};
		prod   = dd_q * $signed({1'b0, dt_q});
		v      = (19'(prod) <<< 1) + $signed({11'b0, den_q});
		// floor division: negative numerators use the ceiling of the magnitude
		dvd    = v[18] ? (~19'(v) + {10'b0, dsor}) : 19'(v);
		rsh    = {rem_q[8:0], qd_q[DVD_W-1]};
		ge     = rsh >= {1'b0, dsor};
		sq     = neg_q ? (~{2'b0, qd_q} + 19'd1) : {2'b0, qd_q};
		sum    = {11'b0, d0_q} + sq;
		if (sum[18]) begin
			duty_fin = 7'd0;
		end else if (sum > 19'(fcdc_pkg::FULL_DUTY)) begin
			duty_fin = fcdc_pkg::FULL_DUTY;
		end else begin
			duty_fin = sum[6:0];
		end
		q_pop     = (state_q == S_IDLE) && q_valid;
		out_valid = out_valid_q;
		out_data  = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_entry.fixed) begin
							res_q   <= q_entry.res;
							state_q <= S_DONE;
						end else begin
							temp_q  <= q_entry.temp;
							idx_q   <= '0;
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (idx_q == n_lim) begin
						res_q.duty_percent <= fcdc_pkg::FULL_DUTY;
						res_q.duty_reason  <= fcdc_pkg::REASON_ABOVE;
						state_q            <= S_DONE;
					end else if (t_cur > temp_q) begin
						if (idx_q == 4'd0) begin
							res_q.duty_percent <= fcdc_pkg::sat_duty(d_cur);
							res_q.duty_reason  <= fcdc_pkg::REASON_BELOW;
							state_q            <= S_DONE;
						end else begin
							dd_q    <= $signed({1'b0, d_cur}) - $signed({1'b0, d_prev});
							dt_q    <= temp_q - t_prev;
							den_q   <= t_cur - t_prev;
							d0_q    <= d_prev;
							state_q <= S_MUL;
						end
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_MUL: begin
					neg_q   <= v[18];
					qd_q    <= dvd[DVD_W-1:0];
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? (rsh - {1'b0, dsor}) : rsh;
					qd_q  <= {qd_q[DVD_W-2:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DVD_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_q.duty_percent <= duty_fin;
					res_q.duty_reason  <= fcdc_pkg::REASON_INTERP;
					state_q            <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.duty_percent <= fcdc_pkg::FULL_DUTY)
		else $error("duty above full scale");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> cnt_q < 5'(DVD_W))
		else $error("divide step count overrun");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> rem_q < {1'b0, dsor})
		else $error("partial remainder not below divisor");

	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> idx_q <= n_lim)
		else $error("curve walk past last point");

endmodule

`default_nettype wire

/* dv/fcdc_duty_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcdc_duty_checker: result predictor and comparator for the fan duty block
// Mirrors register writes and accepted requests to predict each fan duty
// result, then compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module fcdc_duty_checker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  rd_valid,
	input  wire                  rd_ready,
	input  fcdc_pkg::item_t      rd_data,
	input  wire                  res_valid,
	input  wire                  res_ready,
	input  fcdc_pkg::result_t    res_data,
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  fcdc_pkg::cfg_req_t   cfg_data,
	output int                   fail_count,
	output int                   duty_pending,
	output int                   results_seen,
	output logic [4:0]           reasons_seen
);

	logic [3:0]  curve_len;
	logic [63:0] pt_temps;
	logic [63:0] pt_duties;
	logic [63:0] skip0;
	logic [63:0] skip1;
	logic [15:0] quiet_limit;
	logic        prof_en;

	logic [7:0]  open_max;
	logic        open_good;
	logic [7:0]  slot_peak [2];
	logic        got_reading;
	logic [15:0] quiet_secs;
	logic        armed;

	fcdc_pkg::result_t duty_expect_q [$];
	logic              rearm;
	logic [63:0]       mask;
	fcdc_pkg::result_t want;

	function automatic logic [6:0] clip_pct(input longint d);
		if (d < 0)
			return 7'd0;
		if (d > 100)
			return fcdc_pkg::FULL_DUTY;
		return d[6:0];
	endfunction

	function automatic fcdc_pkg::result_t curve_duty(input logic unreliable);
		fcdc_pkg::result_t r;
		logic [7:0] hot;
		int n;
		int i;
		longint t0, t1, d0, d1, num, den, v, q;
		if (!got_reading || unreliable) begin
			r.duty_percent = fcdc_pkg::FULL_DUTY;
			r.duty_reason = fcdc_pkg::REASON_NO_TEMP;
			return r;
		end
		hot = (slot_peak[1] > slot_peak[0]) ? slot_peak[1] : slot_peak[0];
		n = (curve_len > 8) ? 8 : int'(curve_len);
		i = 0;
		while (i < n && pt_temps[8*i +: 8] <= hot)
			i++;
		if (i == n) begin
			r.duty_percent = fcdc_pkg::FULL_DUTY;
			r.duty_reason = fcdc_pkg::REASON_ABOVE;
			return r;
		end
		if (i == 0) begin
			r.duty_percent = clip_pct(longint'(pt_duties[7:0]));
			r.duty_reason = fcdc_pkg::REASON_BELOW;
			return r;
		end
		t0 = longint'(pt_temps[8*(i-1) +: 8]);
		t1 = longint'(pt_temps[8*i +: 8]);
		d0 = longint'(pt_duties[8*(i-1) +: 8]);
		d1 = longint'(pt_duties[8*i +: 8]);
		num = (d1 - d0) * (longint'(hot) - t0);
		den = t1 - t0;
		v = 2 * num + den;
		// round half up, floor on falling spans
		if (v >= 0)
			q = v / (2 * den);
		else
			q = -((-v + 2 * den - 1) / (2 * den));
		r.duty_percent = clip_pct(d0 + q);
		r.duty_reason = fcdc_pkg::REASON_INTERP;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_len = '0;
			pt_temps = '0;
			pt_duties = '0;
			skip0 = '0;
			skip1 = '0;
			quiet_limit = fcdc_pkg::SILENCE_RESET;
			prof_en = 1'b0;
			open_max = '0;
			open_good = 1'b0;
			slot_peak[0] = '0;
			slot_peak[1] = '0;
			got_reading = 1'b0;
			quiet_secs = '0;
			armed = 1'b0;
			duty_expect_q.delete();
			fail_count = 0;
			duty_pending = 0;
			results_seen = 0;
			reasons_seen = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rearm = 1'b0;
				case (cfg_data.index)
					fcdc_pkg::REG_POINT_COUNT: begin
						curve_len = cfg_data.value[3:0];
						rearm = 1'b1;
					end
					fcdc_pkg::REG_POINT_TEMPS: begin
						pt_temps = cfg_data.value;
						rearm = 1'b1;
					end
					fcdc_pkg::REG_POINT_DUTIES: begin
						pt_duties = cfg_data.value;
						rearm = 1'b1;
					end
					fcdc_pkg::REG_SKIP_MASK0: skip0 = cfg_data.value;
					fcdc_pkg::REG_SKIP_MASK1: skip1 = cfg_data.value;
					fcdc_pkg::REG_SILENCE_LIMIT: quiet_limit = cfg_data.value[15:0];
					fcdc_pkg::REG_PROFILE_EN: begin
						prof_en = cfg_data.value[0];
						rearm = 1'b1;
					end
					default: ;
				endcase
				if (rearm) begin
					if (prof_en) begin
						if (!armed)
							quiet_secs = '0;
						armed = 1'b1;
					end else begin
						armed = 1'b0;
					end
				end
			end

			if (rd_valid && rd_ready) begin
				if (rd_data.func) begin
					if (armed) begin
						if (quiet_secs != 16'hFFFF)
							quiet_secs++;
						if (quiet_secs > quiet_limit) begin
							armed = 1'b0;
							want.duty_percent = fcdc_pkg::FULL_DUTY;
							want.duty_reason = fcdc_pkg::REASON_SILENCE;
							duty_expect_q.push_back(want);
						end
					end
				end else begin
					mask = rd_data.slot ? skip1 : skip0;
					if (rd_data.parse_ok && !mask[rd_data.channel]) begin
						if (rd_data.temp_value > open_max)
							open_max = rd_data.temp_value;
						open_good = 1'b1;
					end
					if (rd_data.last_in_report) begin
						if (open_good) begin
							got_reading = 1'b1;
							slot_peak[rd_data.slot] = open_max;
							quiet_secs = '0;
						end
						open_max = '0;
						open_good = 1'b0;
						if (armed)
							duty_expect_q.push_back(curve_duty(rd_data.sensor_unreliable));
					end
				end
			end

			if (res_valid && res_ready) begin
				results_seen++;
				if (res_data.duty_reason <= fcdc_pkg::REASON_SILENCE)
					reasons_seen[res_data.duty_reason] = 1'b1;
				if (duty_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected duty result: duty %0d reason %0d",
							res_data.duty_percent, res_data.duty_reason);
				end else begin
					want = duty_expect_q.pop_front();
					if (res_data.duty_percent !== want.duty_percent ||
						res_data.duty_reason !== want.duty_reason) begin
						fail_count++;
						if (fail_count <= 10)
							$display("duty mismatch: got %0d/%0d, expected %0d/%0d",
								res_data.duty_percent, res_data.duty_reason,
								want.duty_percent, want.duty_reason);
					end
				end
			end

			duty_pending = duty_expect_q.size();
		end
	end

endmodule

/* dv/tb_fan_curve_duty_controller.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fan_curve_duty_controller: testbench top of the fan duty controller
// Directed curve, mask and watchdog cases, then randomized profiles with
// well-formed and broken reports, ticks, idle gaps and a long result stall.
// ----------------------------------------------------------------------------

module tb_fan_curve_duty_controller;

	localparam int          CYCLE_LIMIT = 500000;
	localparam int          DRAIN_WAIT  = 40;
	localparam int          HOLD_CYCLES = 600;
	localparam int          PHASES      = 10;
	localparam int          PHASE_ITEMS = 153;
	localparam logic [2:0]  REG_SPARE   = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   gaps_on = 1'b1;
	bit   hold_kick = 1'b0;
	int   items_sent = 0;
	int   profiles = 0;
	int   cycles = 0;

	int         fail_count;
	int         duty_pending;
	int         results_seen;
	logic [4:0] reasons_seen;

	fcdc_stream_if #(.T(fcdc_pkg::item_t))    rd_if ();
	fcdc_stream_if #(.T(fcdc_pkg::result_t))  res_if ();
	fcdc_stream_if #(.T(fcdc_pkg::cfg_req_t)) cfg_if ();

	fan_curve_duty_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.reading(rd_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	fcdc_duty_checker duty_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_valid    (rd_if.valid),
		.rd_ready    (rd_if.ready),
		.rd_data     (rd_if.data),
		.res_valid   (res_if.valid),
		.res_ready   (res_if.ready),
		.res_data    (res_if.data),
		.cfg_valid   (cfg_if.valid),
		.cfg_ready   (cfg_if.ready),
		.cfg_data    (cfg_if.data),
		.fail_count  (fail_count),
		.duty_pending(duty_pending),
		.results_seen(results_seen),
		.reasons_seen(reasons_seen)
	);

	always #4 clk = ~clk;

	initial begin
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, duty_pending);
		$display("*** FAILED ***");
		$finish;
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready = 1'b0;
			end else begin
				res_if.ready = !(gaps_on && $urandom_range(99) < 15);
			end
		end
	end

	function automatic fcdc_pkg::item_t read_item(input bit slot, input logic [5:0] ch,
		input logic [7:0] t, input bit ok, input bit last, input bit unrel);
		fcdc_pkg::item_t it;
		it.func = 1'b0;
		it.slot = slot;
		it.channel = ch;
		it.temp_value = t;
		it.parse_ok = ok;
		it.last_in_report = last;
		it.sensor_unreliable = unrel;
		return it;
	endfunction

	function automatic fcdc_pkg::item_t tick_item();
		fcdc_pkg::item_t it;
		it = fcdc_pkg::item_t'(19'($urandom));
		it.func = 1'b1;
		return it;
	endfunction

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		cfg_if.valid = 1'b1;
		cfg_if.data.index = idx;
		cfg_if.data.value = val;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic send(input fcdc_pkg::item_t it);
		while (gaps_on && $urandom_range(99) < 15) begin
			rd_if.valid = 1'b0;
			@(negedge clk);
		end
		rd_if.valid = 1'b1;
		rd_if.data = it;
		do @(posedge clk); while (!rd_if.ready);
		@(negedge clk);
		rd_if.valid = 1'b0;
		items_sent++;
	endtask

	task automatic send_report(input bit clean);
		logic [5:0] ch;
		logic [7:0] t;
		int len;
		bit slot;
		bit ends;
		slot = 1'($urandom_range(1));
		len = $urandom_range(1, 5);
		ch = 6'($urandom);
		ends = clean || ($urandom_range(1) == 1);
		for (int k = 0; k < len; k++) begin
			t = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(130));
			send(read_item(slot, ch, t,
				clean ? ($urandom_range(19) != 0) : ($urandom_range(1) == 1),
				ends && k == len - 1, $urandom_range(15) == 0));
			ch++;
		end
	endtask

	task automatic settle();
		while (duty_pending != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	initial begin
		int target;
		int pick;
		int tv;
		int dv;
		int sel;
		logic [63:0] tw;
		logic [63:0] dw;
		logic [3:0] cnt;
		rd_if.valid = 1'b0;
		rd_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// four point curve 30/40/50/60 C -> 20/40/70/100 %
		cfg_write(fcdc_pkg::REG_POINT_COUNT, 64'd4);
		cfg_write(fcdc_pkg::REG_POINT_TEMPS, 64'h3C32_281E);
		cfg_write(fcdc_pkg::REG_POINT_DUTIES, 64'h6446_2814);
		cfg_write(fcdc_pkg::REG_SILENCE_LIMIT, 64'd3);
		cfg_write(fcdc_pkg::REG_PROFILE_EN, 64'd1);
		profiles++;
		send(read_item(0, 0, 8'd0, 0, 1, 0));
		send(read_item(0, 0, 8'd20, 1, 0, 0));
		send(read_item(0, 1, 8'd25, 1, 1, 0));
		send(read_item(1, 63, 8'd45, 1, 1, 0));
		send(read_item(1, 2, 8'd60, 1, 1, 0));
		send(read_item(1, 3, 8'd35, 1, 1, 1));
		send(read_item(1, 4, 8'd35, 1, 1, 0));
		send(read_item(0, 5, 8'd255, 1, 1, 0));
		send(read_item(0, 6, 8'd0, 1, 1, 0));
		repeat (4) send(tick_item());
		send(read_item(1, 7, 8'd50, 1, 1, 0));
		send(tick_item());
		settle();

		// masked channels, empty curve
		cfg_write(fcdc_pkg::REG_SKIP_MASK0, 64'h8000_0000_0000_0001);
		cfg_write(fcdc_pkg::REG_SKIP_MASK1, '1);
		cfg_write(fcdc_pkg::REG_POINT_COUNT, 64'd0);
		cfg_write(fcdc_pkg::REG_PROFILE_EN, 64'd1);
		profiles++;
		send(read_item(0, 0, 8'd90, 1, 0, 0));
		send(read_item(0, 63, 8'd95, 1, 1, 0));
		send(read_item(1, 17, 8'd200, 1, 1, 0));
		settle();

		// oversized count, falling span, duty above full, zero watchdog limit
		cfg_write(fcdc_pkg::REG_SKIP_MASK0, 64'd0);
		cfg_write(fcdc_pkg::REG_SKIP_MASK1, 64'd0);
		cfg_write(fcdc_pkg::REG_POINT_COUNT, 64'd15);
		cfg_write(fcdc_pkg::REG_POINT_TEMPS, 64'hFFC8_7850_2814_0A00);
		cfg_write(fcdc_pkg::REG_POINT_DUTIES, 64'h6464_7832_0305_0500);
		cfg_write(fcdc_pkg::REG_SILENCE_LIMIT, 64'd0);
		cfg_write(REG_SPARE, {$urandom, $urandom});
		cfg_write(fcdc_pkg::REG_PROFILE_EN, 64'd1);
		profiles++;
		send(read_item(1, 9, 8'd1, 1, 1, 0));
		send(read_item(0, 10, 8'd35, 1, 1, 0));
		send(read_item(0, 11, 8'd100, 1, 1, 0));
		send(read_item(0, 12, 8'd119, 1, 1, 0));
		send(read_item(0, 13, 8'd255, 1, 1, 0));
		send(tick_item());
		settle();

		for (int p = 0; p < PHASES; p++) begin
			gaps_on = (p != 2);

			sel = $urandom_range(9);
			cnt = 4'((sel == 9) ? $urandom_range(9, 15) : sel);
			tv = $urandom_range(40);
			dv = $urandom_range(30);
			for (int k = 0; k < 8; k++) begin
				tw[8*k +: 8] = 8'(tv);
				dw[8*k +: 8] = 8'(dv);
				tv += $urandom_range(1, 30);
				if (tv > 255)
					tv = 255;
				dv += $urandom_range(20);
				if (dv > 100)
					dv = 100;
			end
			if ($urandom_range(6) == 0)
				tw = {$urandom, $urandom};
			if ($urandom_range(4) == 0)
				dw = {$urandom, $urandom};
			cfg_write(fcdc_pkg::REG_POINT_COUNT, 64'(cnt));
			cfg_write(fcdc_pkg::REG_POINT_TEMPS, tw);
			cfg_write(fcdc_pkg::REG_POINT_DUTIES, dw);
			for (int s = 0; s < 2; s++) begin
				sel = $urandom_range(9);
				if (sel == 0)
					tw = '0;
				else if (sel == 1)
					tw = '1;
				else
					tw = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
				cfg_write(s == 0 ? fcdc_pkg::REG_SKIP_MASK0 : fcdc_pkg::REG_SKIP_MASK1, tw);
			end
			sel = $urandom_range(9);
			if (sel == 0)
				tv = 0;
			else if (sel == 1)
				tv = 65535;
			else if (sel == 2)
				tv = $urandom_range(65535);
			else
				tv = $urandom_range(5, 40);
			cfg_write(fcdc_pkg::REG_SILENCE_LIMIT, 64'(tv));
			cfg_write(fcdc_pkg::REG_PROFILE_EN,
				(p == 6) ? 64'd0 : 64'($urandom_range(9) != 0));
			profiles++;

			if (p == 4)
				hold_kick = !hold_kick;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 70)
					send_report(1'b1);
				else if (pick < 80)
					send_report(1'b0);
				else if (pick < 92)
					send(tick_item());
				else
					send(fcdc_pkg::item_t'(19'($urandom)));
			end
			settle();
		end

		$display("Run: %0d requests over %0d curve profiles, %0d duty results checked",
			items_sent, profiles, results_seen);
		$display("Reasons observed (silence..interp): %b, mismatches: %0d",
			reasons_seen, fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/fcdc_pkg.sv
rtl/core/fcdc_stream_if.sv
rtl/core/fcdc_front.sv
rtl/core/fcdc_queue.sv
rtl/core/fcdc_back.sv
rtl/core/fan_curve_duty_controller.sv
dv/fcdc_duty_checker.sv
dv/tb_fan_curve_duty_controller.sv
